[sv/ppa_pkg.sv]
package ppa_pkg;

  localparam int CHAN_W = 16;
  localparam int PCT_W = 7;
  localparam int COLOUR_W = 3 * PCT_W;
  localparam int STATUS_W = 3;
  localparam int INDEX_W = 8;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int SCALE_W = 7;
  localparam logic [SCALE_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd99;

  localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;

  localparam logic FUNC_LOOKUP  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

endpackage

[sv/ppa_if.sv]
interface ppa_in_if;
  import ppa_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] alpha_in;

  modport source (output valid, func, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, func, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface ppa_out_if;
  import ppa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  entry_index;
  logic [PCT_W-1:0]    red_pct;
  logic [PCT_W-1:0]    green_pct;
  logic [PCT_W-1:0]    blue_pct;

  modport source (output valid, status, entry_index, red_pct, green_pct, blue_pct,
                  input ready);
  modport sink (input valid, status, entry_index, red_pct, green_pct, blue_pct,
                output ready);
endinterface

[sv/pixel_palette_allocator_top.sv]
// A look-up passes through the states IDLE (premultiply registered), PCT (percent
// registered), SCAN and DONE, which loads the output register; a transparent pixel or a
// release goes from IDLE straight to DONE. A new pixel is taken only in IDLE, so only
// after the last result is loaded; the scan reads the colour memory one entry per cycle.
// Reset (rst, synchronous): every entry unused, colours read as zero, output empty.
module pixel_palette_allocator_top #(
  parameter int PALETTE_ENTRIES = ppa_pkg::PALETTE_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst,
  ppa_in_if.sink   pix,
  ppa_out_if.source res
);
  import ppa_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PCT  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [COLOUR_W-1:0] colour_mem [PALETTE_ENTRIES];
  logic [COLOUR_W-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;

  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_inc;
  logic [CNT_W-1:0]    hwm;

  logic [PCT_W-1:0]    red_pct, green_pct, blue_pct;
  logic [COLOUR_W-1:0] key;
  logic [COLOUR_W-1:0] stored;

  logic accept, pass_through, at_fill, hit, last, wr_en, load_out;

  logic [STATUS_W-1:0] rslt_status;
  logic [IDX_W-1:0]    rslt_idx;
  logic                rslt_blank;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_index;
  logic [PCT_W-1:0]    out_red, out_green, out_blue;

  ppa_quant u_quant_red (
    .clk(clk), .pre_en(accept), .pct_en(state == S_PCT),
    .chan(pix.red_in), .alpha(pix.alpha_in), .pct(red_pct)
  );

  ppa_quant u_quant_green (
    .clk(clk), .pre_en(accept), .pct_en(state == S_PCT),
    .chan(pix.green_in), .alpha(pix.alpha_in), .pct(green_pct)
  );

  ppa_quant u_quant_blue (
    .clk(clk), .pre_en(accept), .pct_en(state == S_PCT),
    .chan(pix.blue_in), .alpha(pix.alpha_in), .pct(blue_pct)
  );

  assign pix.ready    = (state == S_IDLE);
  assign accept       = pix.valid && pix.ready;
  assign pass_through = (pix.func == FUNC_RELEASE) || (pix.alpha_in == '0);

  assign key      = {red_pct, green_pct, blue_pct};
  assign stored   = (CNT_W'(idx) < hwm) ? rd_data : '0;
  assign hit      = (stored == key);
  assign at_fill  = (CNT_W'(idx) == fill);
  assign last     = (idx == LAST_IDX);
  assign wr_en    = (state == S_SCAN) && at_fill;
  assign fill_inc = fill + CNT_W'(1);
  assign rd_addr  = (state == S_SCAN) ? idx + IDX_W'(1) : '0;
  assign load_out = (state == S_DONE) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = pass_through ? S_DONE : S_PCT;
        end
      end
      S_PCT: state_next = S_SCAN;
      S_SCAN: begin
        if (at_fill || hit || last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      hwm       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (pix.func == FUNC_RELEASE)) begin
        fill <= '0;
      end
      if (wr_en) begin
        fill <= fill_inc;
        if (fill_inc > hwm) begin
          hwm <= fill_inc;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      colour_mem[idx] <= key;
    end
    rd_data <= colour_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_PCT) begin
      idx <= '0;
    end else if (state == S_SCAN) begin
      idx <= idx + IDX_W'(1);
    end

    if (accept) begin
      rslt_status <= (pix.func == FUNC_RELEASE) ? ST_RELEASED : ST_SKIPPED;
      rslt_idx    <= '0;
      rslt_blank  <= 1'b1;
    end else if (state == S_SCAN) begin
      rslt_blank <= 1'b0;
      if (at_fill) begin
        rslt_status <= hit ? ST_MATCHED : ST_NEW;
        rslt_idx    <= idx;
      end else if (hit) begin
        rslt_status <= ST_MATCHED;
        rslt_idx    <= idx;
      end else begin
        rslt_status <= ST_FULL;
        rslt_idx    <= '0;
      end
    end

    if (load_out) begin
      out_status <= rslt_status;
      out_index  <= INDEX_W'(rslt_idx);
      out_red    <= rslt_blank ? '0 : red_pct;
      out_green  <= rslt_blank ? '0 : green_pct;
      out_blue   <= rslt_blank ? '0 : blue_pct;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.entry_index = out_index;
  assign res.red_pct     = out_red;
  assign res.green_pct   = out_green;
  assign res.blue_pct    = out_blue;

endmodule

[sv/ppa_quant.sv]
module ppa_quant (
  input  logic                       clk,
  input  logic                       pre_en,
  input  logic                       pct_en,
  input  logic [ppa_pkg::CHAN_W-1:0] chan,
  input  logic [ppa_pkg::CHAN_W-1:0] alpha,
  output logic [ppa_pkg::PCT_W-1:0]  pct
);
  import ppa_pkg::*;

  logic [2*CHAN_W-1:0]        pre_prod;
  logic [CHAN_W+SCALE_W-1:0]  pct_prod;
  logic [CHAN_W-1:0]          pre;

  assign pre_prod = chan * alpha;
  assign pct_prod = pre * PCT_SCALE;

  always_ff @(posedge clk) begin
    if (pre_en) begin
      pre <= pre_prod[2*CHAN_W-1:CHAN_W];
    end
    if (pct_en) begin
      pct <= pct_prod[CHAN_W+SCALE_W-1:CHAN_W];
    end
  end

endmodule

[sv/ppa_check.sv]
module ppa_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ppa_pkg::STATUS_W-1:0] status,
  input logic [ppa_pkg::INDEX_W-1:0]  entry_index,
  input logic [ppa_pkg::PCT_W-1:0]    red_pct,
  input logic [ppa_pkg::PCT_W-1:0]    green_pct,
  input logic [ppa_pkg::PCT_W-1:0]    blue_pct
);
  import ppa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index)
      && $stable(red_pct) && $stable(green_pct) && $stable(blue_pct))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new pixel taken while one is in flight");

  a_blank_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SKIPPED || status == ST_RELEASED)
      |-> entry_index == '0 && red_pct == '0 && green_pct == '0 && blue_pct == '0)
    else $error("skipped or released result carries data");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> red_pct <= PCT_MAX && green_pct <= PCT_MAX && blue_pct <= PCT_MAX
      && (status != ST_FULL || entry_index == '0))
    else $error("percent out of range or full result with index");

endmodule

bind pixel_palette_allocator_top ppa_check u_ppa_check (
  .clk(clk),
  .rst(rst),
  .in_valid(pix.valid),
  .in_ready(pix.ready),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .status(res.status),
  .entry_index(res.entry_index),
  .red_pct(res.red_pct),
  .green_pct(res.green_pct),
  .blue_pct(res.blue_pct)
);

[test/pixel_palette_allocator_top_tb.sv]
import ppa_pkg::*;

typedef struct packed {
  logic              func;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;
} pixel_t;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index;
  logic [PCT_W-1:0]    red_pct;
  logic [PCT_W-1:0]    green_pct;
  logic [PCT_W-1:0]    blue_pct;
} outcome_t;

class palette_board;
  logic [COLOUR_W-1:0] colour [PALETTE_ENTRIES_DEF];
  bit                  used [PALETTE_ENTRIES_DEF];
  outcome_t            expected_outcomes [$];
  int                  mismatches;
  int                  checked;

  function new();
    foreach (colour[i]) begin
      colour[i] = '0;
      used[i] = 1'b0;
    end
    mismatches = 0;
    checked = 0;
  endfunction

  function logic [PCT_W-1:0] to_percent(logic [CHAN_W-1:0] chan, logic [CHAN_W-1:0] alpha);
    logic [31:0] premul;
    logic [31:0] scaled;
    premul = {16'd0, chan} * {16'd0, alpha};
    scaled = {16'd0, premul[31:16]} * 32'(PCT_SCALE);
    return scaled[16 +: PCT_W];
  endfunction

  function int first_free();
    int i;
    int found;
    found = -1;
    for (i = PALETTE_ENTRIES_DEF - 1; i >= 0; i--) begin
      if (!used[i]) found = i;
    end
    return found;
  endfunction

  function int pending();
    return expected_outcomes.size();
  endfunction

  function void note_pixel(pixel_t p);
    outcome_t            want;
    logic [COLOUR_W-1:0] key;
    int                  i;
    bit                  done;
    want = '0;
    if (p.func == FUNC_RELEASE) begin
      foreach (used[j]) used[j] = 1'b0;
      want.status = ST_RELEASED;
    end else if (p.alpha == '0) begin
      want.status = ST_SKIPPED;
    end else begin
      want.red_pct = to_percent(p.red, p.alpha);
      want.green_pct = to_percent(p.green, p.alpha);
      want.blue_pct = to_percent(p.blue, p.alpha);
      key = {want.red_pct, want.green_pct, want.blue_pct};
      want.status = ST_FULL;
      done = 1'b0;
      for (i = 0; i < PALETTE_ENTRIES_DEF && !done; i++) begin
        if (colour[i] == key) begin
          used[i] = 1'b1;
          want.status = ST_MATCHED;
          want.index = i[INDEX_W-1:0];
          done = 1'b1;
        end else if (!used[i]) begin
          colour[i] = key;
          used[i] = 1'b1;
          want.status = ST_NEW;
          want.index = i[INDEX_W-1:0];
          done = 1'b1;
        end
      end
    end
    expected_outcomes.push_back(want);
  endfunction

  task report(string msg);
    $display("mismatch on result %0d: %s", checked, msg);
    mismatches++;
  endtask

  task check_outcome(outcome_t got);
    outcome_t want;
    if (expected_outcomes.size() == 0) begin
      report($sformatf("unexpected transaction status %0d", got.status));
    end else begin
      want = expected_outcomes.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.index !== want.index)
        report($sformatf("entry_index %0d, want %0d", got.index, want.index));
      if (got.red_pct !== want.red_pct)
        report($sformatf("red_pct %0d, want %0d", got.red_pct, want.red_pct));
      if (got.green_pct !== want.green_pct)
        report($sformatf("green_pct %0d, want %0d", got.green_pct, want.green_pct));
      if (got.blue_pct !== want.blue_pct)
        report($sformatf("blue_pct %0d, want %0d", got.blue_pct, want.blue_pct));
    end
    checked++;
  endtask
endclass

module pixel_palette_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1700;
  localparam int POOL_DEPTH = 32;

  logic clk;
  logic rst;
  bit   calm;

  palette_board sb = new();
  pixel_t       recent [$];

  ppa_in_if  pix_ch ();
  ppa_out_if res_ch ();

  pixel_palette_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("pixel_palette_allocator_top_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_outcome({res_ch.status, res_ch.entry_index, res_ch.red_pct,
                        res_ch.green_pct, res_ch.blue_pct});
    res_ch.ready <= calm || ($urandom_range(0, 99) >= 38);
  end

  function automatic pixel_t px(logic func, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
    pixel_t p;
    p.func = func;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    return p;
  endfunction

  // smallest nonzero channel value that lands on the given percent at full alpha
  function automatic logic [CHAN_W-1:0] channel_for(logic [PCT_W-1:0] pct);
    logic [31:0] premul;
    premul = (32'(pct) * 32'd65536 + 32'd99) / 32'd100;
    return premul[CHAN_W-1:0] + 16'd1;
  endfunction

  function automatic pixel_t pixel_of(logic [COLOUR_W-1:0] key);
    return px(FUNC_LOOKUP, channel_for(key[2*PCT_W +: PCT_W]),
              channel_for(key[PCT_W +: PCT_W]), channel_for(key[0 +: PCT_W]), 16'hFFFF);
  endfunction

  function automatic pixel_t random_lookup();
    logic [CHAN_W-1:0] a;
    a = ($urandom_range(0, 4) == 0) ? 16'hFFFF : CHAN_W'($urandom_range(1, 65535));
    return px(FUNC_LOOKUP, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), a);
  endfunction

  function automatic pixel_t pick_item(int fresh_pct);
    int roll;
    int slot;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      return px(FUNC_RELEASE, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom));
    if (roll < 8)
      return px(FUNC_LOOKUP, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), '0);
    if ($urandom_range(0, 99) < fresh_pct)
      return random_lookup();
    if ($urandom_range(0, 1) == 0 && recent.size() > 0)
      return recent[$urandom_range(0, recent.size() - 1)];
    slot = sb.first_free();
    if (slot < 0 || $urandom_range(0, 1) == 0)
      slot = $urandom_range(0, PALETTE_ENTRIES_DEF - 1);
    return pixel_of(sb.colour[slot]);
  endfunction

  task automatic send(pixel_t p);
    while (!calm && $urandom_range(0, 99) < 38) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.func <= p.func;
    pix_ch.red_in <= p.red;
    pix_ch.green_in <= p.green;
    pix_ch.blue_in <= p.blue;
    pix_ch.alpha_in <= p.alpha;
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_pixel(p);
    if (p.func == FUNC_LOOKUP && p.alpha != '0) begin
      recent.push_back(p);
      if (recent.size() > POOL_DEPTH) void'(recent.pop_front());
    end
  endtask

  initial begin
    int     run_len;
    int     fresh_pct;
    int     k;
    pixel_t directed [$];

    calm <= 1'b0;
    rst <= 1'b1;
    pix_ch.valid <= 1'b0;
    pix_ch.func <= FUNC_LOOKUP;
    pix_ch.red_in <= '0;
    pix_ch.green_in <= '0;
    pix_ch.blue_in <= '0;
    pix_ch.alpha_in <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed = '{
      px(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
      px(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000),
      px(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      px(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      px(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001),
      px(FUNC_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
      px(FUNC_RELEASE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
      px(FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF),
      px(FUNC_LOOKUP, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA),
      px(FUNC_RELEASE, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
      px(FUNC_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
      px(FUNC_LOOKUP, 16'h0001, 16'h0001, 16'h0001, 16'h0001),
      px(FUNC_LOOKUP, 16'h7FFF, 16'h3FFF, 16'h1FFF, 16'hFFFF)
    };
    foreach (directed[i]) send(directed[i]);

    // fill the palette in runs, each closed by a release
    k = 0;
    while (k < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 480);
      fresh_pct = ($urandom_range(0, 1) == 0) ? 85 : 35;
      while (run_len > 0 && k < RANDOM_ITEMS) begin
        calm <= (k >= 700 && k < 1000);
        send(pick_item(fresh_pct));
        run_len--;
        k++;
      end
      send(px(FUNC_RELEASE, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
              CHAN_W'($urandom)));
      k++;
    end
    pix_ch.valid <= 1'b0;
    calm <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (PALETTE_ENTRIES_DEF + 8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("pixel_palette_allocator_top_tb OK");
    else
      $display("pixel_palette_allocator_top_tb NOT OK");
    $finish;
  end

endmodule

[pixel_palette_allocator_top.f]
sv/ppa_pkg.sv
sv/ppa_if.sv
sv/ppa_quant.sv
sv/pixel_palette_allocator_top.sv
sv/ppa_check.sv
test/pixel_palette_allocator_top_tb.sv
